// File: hw/rtl/wpr_pkg.sv
`timescale 1ns / 1ps
package wpr_pkg;

  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned MAX_WIDTH  = 1023;
  localparam int unsigned MIN_HEIGHT = 4;

  localparam int unsigned Q15_BITS  = 15;
  localparam int unsigned COL_W     = 26;
  localparam int unsigned STEP_W    = 25;
  localparam int unsigned XPOS_W    = 27;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned PROD_W    = 22;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned WIDTH_W   = 10;
  localparam int unsigned HEIGHT_W  = 7;
  localparam int unsigned SCOUNT_W  = 11;
  localparam int unsigned PIXY_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned UA_W      = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

  localparam logic [WIDTH_W-1:0]  BAR_WIDTH_RESET    = 10'd256;
  localparam logic [HEIGHT_W-1:0] BAR_HEIGHT_RESET   = 7'd64;
  localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RESET = 11'd256;
  // 256 * 2^15 / 256
  localparam logic [STEP_W-1:0]   STEP_RESET         = 25'd32768;

  // Microcode addresses
  localparam logic [UA_W-1:0] UA_ACCEPT = 4'd0;
  localparam logic [UA_W-1:0] UA_MUL    = 4'd1;
  localparam logic [UA_W-1:0] UA_LEVEL  = 4'd2;
  localparam logic [UA_W-1:0] UA_DIFF   = 4'd3;
  localparam logic [UA_W-1:0] UA_DREF   = 4'd4;
  localparam logic [UA_W-1:0] UA_WREF   = 4'd5;
  localparam logic [UA_W-1:0] UA_RUN    = 4'd6;
  localparam logic [UA_W-1:0] UA_FINISH = 4'd7;
  localparam logic [UA_W-1:0] UA_SMALL0 = 4'd8;
  localparam logic [UA_W-1:0] UA_SMALL1 = 4'd9;
  localparam logic [UA_W-1:0] UA_DSTEP  = 4'd10;
  localparam logic [UA_W-1:0] UA_WSTEP  = 4'd11;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_FRAME    = 3'd2,
    C_SMALL    = 3'd3,
    C_RUN_MORE = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    SRC_PREV = 2'd0,
    SRC_NEXT = 2'd1,
    SRC_RUN  = 2'd2
  } emit_src_e;

  typedef enum logic {
    DIV_STEP = 1'b0,
    DIV_REF  = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic      in_ack;
    logic      mul_en;
    logic      lvl_en;
    logic      div_start;
    div_sel_e  div_sel;
    logic      step_ld;
    logic      diff_en;
    logic      ref_ld;
    logic      emit;
    emit_src_e emit_src;
    logic      commit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t           ctrl;
    logic            wait_div;
    cond_e           cond;
    logic [UA_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic frame;
    logic small_step;
    logic run_more;
    logic div_busy;
  } status_t;

  function automatic cw_t ucode(input logic [UA_W-1:0] addr);
    cw_t c;
    c = '0;
    case (addr)
      UA_ACCEPT: c.ctrl.in_ack = 1'b1;
      UA_MUL:    c.ctrl.mul_en = 1'b1;
      UA_LEVEL: begin
        c.ctrl.lvl_en = 1'b1;
        c.cond        = C_FRAME;
        c.target      = UA_DSTEP;
      end
      UA_DIFF: begin
        c.ctrl.diff_en = 1'b1;
        c.cond         = C_SMALL;
        c.target       = UA_SMALL0;
      end
      UA_DREF: begin
        c.ctrl.div_start = 1'b1;
        c.ctrl.div_sel   = DIV_REF;
      end
      UA_WREF: begin
        c.wait_div    = 1'b1;
        c.ctrl.ref_ld = 1'b1;
      end
      UA_RUN: begin
        c.ctrl.emit     = 1'b1;
        c.ctrl.emit_src = SRC_RUN;
        c.cond          = C_RUN_MORE;
        c.target        = UA_RUN;
      end
      UA_FINISH: begin
        c.ctrl.commit = 1'b1;
        c.cond        = C_ALWAYS;
        c.target      = UA_ACCEPT;
      end
      UA_SMALL0: begin
        c.ctrl.emit     = 1'b1;
        c.ctrl.emit_src = SRC_PREV;
      end
      UA_SMALL1: begin
        c.ctrl.emit     = 1'b1;
        c.ctrl.emit_src = SRC_NEXT;
        c.cond          = C_ALWAYS;
        c.target        = UA_FINISH;
      end
      UA_DSTEP: begin
        c.ctrl.div_start = 1'b1;
        c.ctrl.div_sel   = DIV_STEP;
      end
      UA_WSTEP: begin
        c.wait_div     = 1'b1;
        c.ctrl.step_ld = 1'b1;
        c.cond         = C_ALWAYS;
        c.target       = UA_ACCEPT;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = UA_ACCEPT;
      end
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/wpr_div.sv
`timescale 1ns / 1ps
module wpr_div
  import wpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [STEP_W-1:0]   dividend_i,
  input  logic [SCOUNT_W-1:0] divisor_i,
  output logic                busy_o,
  output logic [STEP_W-1:0]   quotient_o
);

  localparam int unsigned ITER_W = $clog2(STEP_W + 1);

  logic [SCOUNT_W-1:0] rem_q, rem_d;
  logic [SCOUNT_W-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0]   quo_q, quo_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic [SCOUNT_W:0]   trial;
  logic                fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[STEP_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    iter_d = iter_q;
    if (start_i) begin
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      iter_d = ITER_W'(STEP_W);
    end else if (iter_q != '0) begin
      rem_d  = fits ? SCOUNT_W'(trial - {1'b0, dvs_q}) : trial[SCOUNT_W-1:0];
      quo_d  = {quo_q[STEP_W-2:0], fits};
      iter_d = iter_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else begin
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = iter_q != '0;
  assign quotient_o = quo_q;

endmodule

// File: hw/rtl/wpr_seq.sv
`timescale 1ns / 1ps
module wpr_seq
  import wpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  input  logic    in_valid_i,
  input  logic    out_busy_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  logic [UA_W-1:0] upc_q, upc_d;
  cw_t             cw;
  logic            go;
  logic            taken;

  assign cw = ucode(upc_q);

  // Hold the step while its operand or its sink is not there, or while it waits on a busy divider
  assign go = !(cw.ctrl.in_ack && !in_valid_i)
           && !(cw.ctrl.emit && out_busy_i)
           && !(cw.wait_div && status_i.div_busy);

  always_comb begin
    case (cw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_FRAME:    taken = status_i.frame;
      C_SMALL:    taken = status_i.small_step;
      C_RUN_MORE: taken = status_i.run_more;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (go) begin
      upc_d = taken ? cw.target : upc_q + UA_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_ACCEPT;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_ready_o = cw.ctrl.in_ack;
  assign ctrl_o     = go ? cw.ctrl : '0;

endmodule

// File: hw/rtl/wpr_dp.sv
`timescale 1ns / 1ps
module wpr_dp
  import wpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                frame_start_i,
  input  logic [WIDTH_W-1:0]  bar_width_i,
  input  logic [HEIGHT_W-1:0] bar_height_i,
  input  logic [SCOUNT_W-1:0] sample_count_i,
  output status_t             status_o,
  output logic [WIDTH_W-1:0]  pixel_x_o,
  output logic [PIXY_W-1:0]   pixel_y_o,
  output logic                last_point_o
);

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       frame_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [LEVEL_W-1:0]  level_q;
  logic signed [LEVEL_W-1:0]  prev_q;
  logic [COL_W-1:0]           col_q;
  logic [STEP_W-1:0]          step_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       up_q;
  logic [STEP_W-1:0]          ref_q;
  logic [XPOS_W-1:0]          x_q;
  logic signed [LEVEL_W-1:0]  row_q;
  logic [CNT_W-1:0]           idx_q;

  logic [HEIGHT_W-2:0]        half;
  logic [4:0]                 scale;
  logic signed [LEVEL_W:0]    diff;
  logic [LEVEL_W:0]           abs_diff;
  logic [XPOS_W-1:0]          col_end;
  logic                       run_last;
  logic [STEP_W-1:0]          dvd;
  logic [SCOUNT_W-1:0]        dvs;
  logic                       div_busy;
  logic [STEP_W-1:0]          quotient;
  logic [XPOS_W-1:0]          emit_x;
  logic signed [LEVEL_W-1:0]  emit_row;
  logic [LEVEL_W-1:0]         emit_y;

  assign half     = bar_height_i[HEIGHT_W-1:1];
  assign scale    = 5'(half - (HEIGHT_W-1)'(1));
  assign diff     = {level_q[LEVEL_W-1], level_q} - {prev_q[LEVEL_W-1], prev_q};
  assign abs_diff = diff[LEVEL_W] ? -diff : diff;
  assign col_end  = {1'b0, col_q} + {2'b00, step_q};
  assign run_last = idx_q == cnt_q - CNT_W'(1);

  always_comb begin
    if (ctrl_i.div_sel == DIV_STEP) begin
      dvd = {bar_width_i, Q15_BITS'(0)};
      dvs = (sample_count_i == '0) ? SCOUNT_W'(1) : sample_count_i;
    end else begin
      dvd = step_q;
      dvs = SCOUNT_W'(cnt_q + CNT_W'(1));
    end
  end

  wpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_ack) begin
      sample_q <= sample_i;
      frame_q  <= frame_start_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(sample_q) * PROD_W'($signed({1'b0, scale}));
    end
    if (ctrl_i.lvl_en) begin
      // arithmetic shift gives the floor
      level_q <= prod_q[PROD_W-1:Q15_BITS];
    end
    if (ctrl_i.diff_en) begin
      cnt_q <= abs_diff[CNT_W-1:0];
      up_q  <= !diff[LEVEL_W];
    end
    if (ctrl_i.ref_ld) begin
      ref_q <= quotient;
      x_q   <= up_q ? {1'b0, col_q} : col_end;
      row_q <= up_q ? prev_q : level_q;
      idx_q <= '0;
    end else if (ctrl_i.emit && ctrl_i.emit_src == SRC_RUN) begin
      x_q   <= up_q ? x_q + {2'b00, ref_q} : x_q - {2'b00, ref_q};
      row_q <= row_q + LEVEL_W'(1);
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      col_q  <= '0;
      step_q <= STEP_RESET;
    end else if (ctrl_i.step_ld) begin
      prev_q <= level_q;
      col_q  <= '0;
      step_q <= quotient;
    end else if (ctrl_i.commit) begin
      prev_q <= level_q;
      col_q  <= col_end[COL_W-1:0];
    end
  end

  always_comb begin
    case (ctrl_i.emit_src)
      SRC_PREV: begin
        emit_x       = {1'b0, col_q};
        emit_row     = prev_q;
        last_point_o = 1'b0;
      end
      SRC_NEXT: begin
        emit_x       = col_end;
        emit_row     = level_q;
        last_point_o = 1'b1;
      end
      SRC_RUN: begin
        emit_x       = x_q;
        emit_row     = row_q;
        last_point_o = run_last;
      end
      default: begin
        emit_x       = x_q;
        emit_row     = row_q;
        last_point_o = 1'b0;
      end
    endcase
  end

  assign emit_y    = {1'b0, half} - emit_row;
  assign pixel_x_o = emit_x[Q15_BITS+WIDTH_W-1:Q15_BITS];
  assign pixel_y_o = emit_y[PIXY_W-1:0];

  assign status_o.frame      = frame_q;
  assign status_o.small_step = (diff >= $signed(-(LEVEL_W+1)'(1)))
                            && (diff <= $signed((LEVEL_W+1)'(1)));
  assign status_o.run_more   = !run_last;
  assign status_o.div_busy   = div_busy;

endmodule

// File: hw/rtl/waveform_polyline_rasterizer.sv
`timescale 1ns / 1ps
// Waveform polyline rasterizer: turns Q15 amplitude samples into pixel
// coordinates of a polyline inside a bar of bar_width x bar_height pixels.
// Input stream s_axis: tdata[15:0] is the signed sample, tuser flags the
// first sample of a frame (it restarts the column and draws nothing).
// Output stream m_axis: one request per pixel, tdata = {row, column},
// tlast set on the final pixel of a sample.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 bar_width, 1 bar_height, 2 sample_count); write only while idle.
// The width and sample count feed the column step at the next frame start.
// One sample is handled at a time by a microcoded sequencer:
//   frame start:            column step division, no pixel
//   change of up to 1 row:  two pixels
//   change of n rows:       n pixels (column step divided by n + 1, then
//                           one pixel a cycle unless the receiver stalls)
// When the receiver stalls, the pixel waits in the output register and
// the sequencer holds.
// Reset restores default configuration, level 0, column 0, step 1.0 px.
module waveform_polyline_rasterizer
  import wpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [15:0] sample
  input  logic                 s_axis_tuser,  // [0] frame_start
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // [9:0] pixel_x, [15:10] pixel_y
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SCOUNT_W-1:0]  cfg_data_i
);

  logic [WIDTH_W-1:0]  bar_width_q;
  logic [HEIGHT_W-1:0] bar_height_q;
  logic [SCOUNT_W-1:0] sample_count_q;
  logic [HEIGHT_W-1:0] height_in;

  logic                out_valid_q;
  logic [15:0]         out_data_q;
  logic                out_last_q;
  logic                out_busy;

  status_t             status;
  ctrl_t               ctrl;
  logic [WIDTH_W-1:0]  pixel_x;
  logic [PIXY_W-1:0]   pixel_y;
  logic                last_point;

  assign height_in = cfg_data_i[HEIGHT_W-1:0];

  // Saturate the height into the drawable range on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_width_q    <= BAR_WIDTH_RESET;
      bar_height_q   <= BAR_HEIGHT_RESET;
      sample_count_q <= SAMPLE_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BAR_WIDTH: begin
          bar_width_q <= (cfg_data_i[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) ?
                         WIDTH_W'(MAX_WIDTH) : cfg_data_i[WIDTH_W-1:0];
        end
        CFG_BAR_HEIGHT: begin
          if (height_in < HEIGHT_W'(MIN_HEIGHT)) begin
            bar_height_q <= HEIGHT_W'(MIN_HEIGHT);
          end else if (height_in > HEIGHT_W'(MAX_HEIGHT)) begin
            bar_height_q <= HEIGHT_W'(MAX_HEIGHT);
          end else begin
            bar_height_q <= height_in;
          end
        end
        CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_busy = out_valid_q && !m_axis_tready;

  wpr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  wpr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sample_i       (s_axis_tdata),
    .frame_start_i  (s_axis_tuser),
    .bar_width_i    (bar_width_q),
    .bar_height_i   (bar_height_q),
    .sample_count_i (sample_count_q),
    .status_o       (status),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .last_point_o   (last_point)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= {pixel_y, pixel_x};
      out_last_q <= last_point;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: test/wpr_pixel_checker.sv
`timescale 1ns / 1ps
module wpr_pixel_checker
  import wpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [15:0] sample
  input  logic                 s_axis_tuser,  // [0] frame_start
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,  // [9:0] pixel_x, [15:10] pixel_y
  input  logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SCOUNT_W-1:0]  cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [WIDTH_W-1:0] x;
    logic [PIXY_W-1:0]  y;
    logic               last;
  } pixel_t;

  logic [WIDTH_W-1:0]         width_r;
  logic [HEIGHT_W-1:0]        height_r;
  logic [SCOUNT_W-1:0]        count_r;
  logic signed [LEVEL_W-1:0]  prev_level;
  logic [COL_W-1:0]           column_q15;
  logic [STEP_W-1:0]          step_q15;

  pixel_t      expected_pixels[$];
  int unsigned mismatches = 0;
  int unsigned pixel_index = 0;

  function automatic logic [STEP_W-1:0] column_step();
    logic [31:0] divisor;
    divisor = (count_r == '0) ? 32'd1 : 32'(count_r);
    return STEP_W'((32'(width_r) << Q15_BITS) / divisor);
  endfunction

  // floor(sample * (height/2 - 1) / 2^15)
  function automatic int sample_level(logic [15:0] raw);
    int amp;
    int scale;
    amp   = int'($signed(raw));
    scale = int'(height_r >> 1) - 1;
    return (amp * scale) >>> Q15_BITS;
  endfunction

  function automatic void push_pixel(logic [31:0] x, int row, logic last);
    int     y;
    pixel_t p;
    y      = int'(height_r >> 1) - row;
    p.x    = x[Q15_BITS +: WIDTH_W];
    p.y    = y[PIXY_W-1:0];
    p.last = last;
    expected_pixels.push_back(p);
  endfunction

  function automatic void plot_sample(logic [15:0] raw, logic frame_start);
    int          level;
    int          prev;
    int          diff;
    int          rows;
    int          row;
    logic [31:0] col_end;
    logic [31:0] x;
    logic [31:0] slope;
    level = sample_level(raw);
    prev  = prev_level;
    if (frame_start) begin
      step_q15   = column_step();
      column_q15 = '0;
      prev_level = LEVEL_W'(level);
      return;
    end
    col_end = 32'(column_q15) + 32'(step_q15);
    diff    = level - prev;
    if (diff >= -1 && diff <= 1) begin
      push_pixel(32'(column_q15), prev, 1'b0);
      push_pixel(col_end, level, 1'b1);
    end else begin
      rows  = (diff < 0) ? -diff : diff;
      slope = 32'(step_q15) / 32'(rows + 1);
      row   = (prev < level) ? prev : level;
      // rising runs walk right from the start, falling ones left from the end
      x     = (prev < level) ? 32'(column_q15) : col_end;
      for (int i = 0; i < rows; i++) begin
        push_pixel(x, row, i == rows - 1);
        row++;
        x = (prev < level) ? x + slope : x - slope;
      end
    end
    column_q15 = col_end[COL_W-1:0];
    prev_level = LEVEL_W'(level);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t           want;
    pixel_t           got;
    logic [HEIGHT_W-1:0] h;
    if (!rst_ni) begin
      width_r    = BAR_WIDTH_RESET;
      height_r   = BAR_HEIGHT_RESET;
      count_r    = SAMPLE_COUNT_RESET;
      prev_level = '0;
      column_q15 = '0;
      step_q15   = column_step();
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BAR_WIDTH:    width_r = cfg_data_i[WIDTH_W-1:0];
          CFG_BAR_HEIGHT: begin
            h = cfg_data_i[HEIGHT_W-1:0];
            if (h < MIN_HEIGHT) h = HEIGHT_W'(MIN_HEIGHT);
            if (h > MAX_HEIGHT) h = HEIGHT_W'(MAX_HEIGHT);
            height_r = h;
          end
          CFG_SAMPLE_COUNT: count_r = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        plot_sample(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = m_axis_tdata[WIDTH_W-1:0];
        got.y    = m_axis_tdata[WIDTH_W +: PIXY_W];
        got.last = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10) begin
            $display("ERROR pixel %0d: none expected, got x=%0d y=%0d last=%0b",
                     pixel_index, got.x, got.y, got.last);
          end
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.x != got.x || want.y != got.y || want.last != got.last) begin
            if (mismatches < 10) begin
              $display("ERROR pixel %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       pixel_index, want.x, want.y, want.last, got.x, got.y, got.last);
            end
            mismatches++;
          end
        end
        pixel_index++;
      end
    end
    pending_o        <= expected_pixels.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// File: test/tb_waveform_polyline_rasterizer.sv
`timescale 1ns / 1ps
module tb_waveform_polyline_rasterizer;
  import wpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;  // [15:0] sample
  logic                 s_axis_tuser = 1'b0;  // [0] frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;  // [9:0] pixel_x, [15:10] pixel_y
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SCOUNT_W-1:0]  cfg_data_i = '0;

  int unsigned mismatch_count;
  int unsigned pending_pixels;

  int          gap_pct = 30;
  int          stall_pct = 30;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [15:0] last_sample = '0;

  waveform_polyline_rasterizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wpr_pixel_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_pixels)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 6);
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [15:0] smp, input logic frame_start);
    logic ok;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= frame_start;
    // sample ready away from the edge, the request goes at the next edge
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    last_sample = smp;
  endtask

  // Drain all pixels, then let a frame start finish its step division
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_pixels != 0);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCOUNT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic random_config();
    write_reg(CFG_BAR_WIDTH, SCOUNT_W'($urandom));
    write_reg(CFG_BAR_HEIGHT, SCOUNT_W'($urandom_range(0, 127)));
    write_reg(CFG_SAMPLE_COUNT, $urandom_range(0, 1) ? SCOUNT_W'($urandom)
                                                     : SCOUNT_W'($urandom_range(2, 64)));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom);
      // near the last sample: mostly changes of a row or less
      4, 5, 6:    v = last_sample + 16'($urandom_range(0, 1600)) - 16'd800;
      7:          v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      8:          v = 16'($urandom_range(0, 64)) - 16'd32;
      default:    v = -last_sample;
    endcase
    return v;
  endfunction

  // Mostly frames opened by a frame start, with stray restarts and headless runs
  task automatic run_frames(input int items);
    logic frame_start;
    for (int i = 0; i < items; i++) begin
      if (i == 0) frame_start = ($urandom_range(0, 9) != 0);
      else frame_start = ($urandom_range(0, 11) == 0);
      send_sample(pick_sample(), frame_start);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, drawing before any frame start
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0422, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    settle();

    // Widest bar, zero sample count: column wraps every other sample
    write_reg(CFG_BAR_WIDTH, 11'h7FF);
    write_reg(CFG_BAR_HEIGHT, 11'd127);
    write_reg(CFG_SAMPLE_COUNT, 11'd0);
    cfg_we_i <= 1'b0;
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    run_frames(10);
    settle();

    // Zero width, height below the minimum
    write_reg(CFG_BAR_WIDTH, 11'd0);
    write_reg(CFG_BAR_HEIGHT, 11'd0);
    write_reg(CFG_SAMPLE_COUNT, 11'd1);
    cfg_we_i <= 1'b0;
    run_frames(12);
    settle();

    write_reg(CFG_BAR_WIDTH, 11'd1);
    write_reg(CFG_BAR_HEIGHT, 11'd4);
    write_reg(CFG_SAMPLE_COUNT, 11'h7FF);
    write_reg(CFG_SPARE, SCOUNT_W'($urandom));
    cfg_we_i <= 1'b0;
    run_frames(12);
    settle();

    write_reg(CFG_BAR_WIDTH, 11'd1023);
    write_reg(CFG_BAR_HEIGHT, 11'd3);
    write_reg(CFG_SAMPLE_COUNT, 11'd1024);
    cfg_we_i <= 1'b0;
    run_frames(12);
    settle();

    for (int p = 0; p < 3; p++) begin
      random_config();
      gap_pct   = 20 * $urandom_range(0, 2);
      stall_pct = 20 * $urandom_range(0, 2);
      run_frames(13);
      settle();
    end

    // Closing stretch at full rate
    gap_pct   = 0;
    stall_pct = 0;
    random_config();
    run_frames(12);
    settle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
